// ===== sv/rcft_pkg.sv =====
`timescale 1ns / 1ps

package rcft_pkg;

	// Table geometry
	localparam int NUM_REGS = 1024;
	localparam int REG_W    = 10;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int CNT_W    = IDX_W + 1;

	typedef logic [REG_W-1:0] reg_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Item kinds carried on the action field
	typedef enum logic [1:0] {
		ACT_BLOCK = 2'd0,
		ACT_INSTR = 2'd1,
		ACT_ARG   = 2'd2
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SWEEP,
		CS_LOOK_A,
		CS_LOOK_B,
		CS_LOOK_C,
		CS_WRITE,
		CS_DONE
	} ctrl_state_t;

	// One table entry: copy origin and its valid flag
	typedef struct packed {
		logic valid;
		reg_t src;
	} entry_t;

	// Table access request
	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
	} mem_req_t;

	// Work list for one item, decoded at acceptance
	typedef struct packed {
		logic pre_clear;
		logic ka_en;
		reg_t ka;
		logic kb_en;
		reg_t kb;
		logic look1;
		reg_t r1;
		logic look2;
		reg_t r2;
		logic pass1;
		logic pass2;
		logic post_en;
		reg_t post_r;
		logic rec_en;
		reg_t rec_dest;
		reg_t rec_src;
	} plan_t;

	function automatic logic in_range(reg_t r);
		return 32'(r) < 32'(NUM_REGS);
	endfunction

	function automatic idx_t to_idx(reg_t r);
		logic [31:0] w;
		w = 32'(r);
		return w[IDX_W-1:0];
	endfunction

	function automatic logic idx_is(idx_t a, reg_t r);
		return 32'(a) == 32'(r);
	endfunction

endpackage

// ===== sv/rcft_table.sv =====
`timescale 1ns / 1ps

module rcft_table (
	input  logic              clk,
	input  rcft_pkg::mem_req_t req,
	output rcft_pkg::entry_t   rd_data_q
);
	import rcft_pkg::*;

	entry_t mem_q [NUM_REGS];

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

endmodule

// ===== sv/rcft_ctrl.sv =====
`timescale 1ns / 1ps

module rcft_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcft_pkg::plan_t    plan,
	input  logic               take,
	input  rcft_pkg::entry_t   rd_data,
	output rcft_pkg::mem_req_t mem_req,
	output logic               idle,
	output logic               done,
	output rcft_pkg::reg_t     t1,
	output rcft_pkg::reg_t     t2
);
	import rcft_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        init_q, init_d;
	logic        post_q, post_d;
	logic        op2_q, op2_d;
	cnt_t        cnt_q;
	logic        sweep_v_s1;
	idx_t        sweep_addr_s1;
	reg_t        mid_q;
	reg_t        t1_q, t2_q;

	logic        sw_clr, sw_ka_en, sw_kb_en;
	reg_t        sw_ka, sw_kb;
	logic        hit;
	logic        mid_load, res_load;
	reg_t        res_val;
	reg_t        look_r;
	ctrl_state_t pre_next, post_next, look_next;
	logic        pre_op2, look_op2;

	// Sweep settings follow the phase: clearing pass, pre-lookup or post-lookup
	assign sw_clr   = init_q || (!post_q && plan.pre_clear);
	assign sw_ka_en = !init_q && (post_q ? plan.post_en : plan.ka_en);
	assign sw_ka    = post_q ? plan.post_r : plan.ka;
	assign sw_kb_en = !init_q && !post_q && plan.kb_en;
	assign sw_kb    = plan.kb;

	// Entry under sweep is hit when it is a killed register or points to one
	assign hit = (sw_ka_en && (idx_is(sweep_addr_s1, sw_ka) || rd_data.src == sw_ka)) ||
		(sw_kb_en && (idx_is(sweep_addr_s1, sw_kb) || rd_data.src == sw_kb));

	assign look_r = op2_q ? plan.r2 : plan.r1;

	// Successor states after each phase
	always_comb begin
		if (plan.post_en) begin
			post_next = CS_SWEEP;
		end else if (plan.rec_en) begin
			post_next = CS_WRITE;
		end else begin
			post_next = CS_DONE;
		end

		if (plan.look1) begin
			pre_next = CS_LOOK_A;
			pre_op2  = 1'b0;
		end else if (plan.look2) begin
			pre_next = CS_LOOK_A;
			pre_op2  = 1'b1;
		end else begin
			pre_next = post_next;
			pre_op2  = 1'b0;
		end

		if (!op2_q && plan.look2) begin
			look_next = CS_LOOK_A;
			look_op2  = 1'b1;
		end else begin
			look_next = post_next;
			look_op2  = op2_q;
		end
	end

	// Next state and table requests
	always_comb begin
		state_d  = state_q;
		init_d   = init_q;
		post_d   = post_q;
		op2_d    = op2_q;
		mem_req  = '0;
		mid_load = 1'b0;
		res_load = 1'b0;
		res_val  = look_r;
		idle     = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (plan.pre_clear || plan.ka_en || plan.kb_en) begin
						state_d = CS_SWEEP;
						post_d  = 1'b0;
					end else begin
						state_d = pre_next;
						op2_d   = pre_op2;
						post_d  = 1'b1;
					end
				end
			end
			CS_SWEEP: begin
				mem_req.rd_en   = 32'(cnt_q) < 32'(NUM_REGS);
				mem_req.rd_addr = cnt_q[IDX_W-1:0];
				mem_req.wr_en   = sweep_v_s1 && (sw_clr || (rd_data.valid && hit));
				mem_req.wr_addr = sweep_addr_s1;
				mem_req.wr_data = '{valid: 1'b0, src: rd_data.src};
				if (32'(cnt_q) == 32'(NUM_REGS)) begin
					if (init_q) begin
						state_d = CS_IDLE;
						init_d  = 1'b0;
					end else if (!post_q) begin
						state_d = pre_next;
						op2_d   = pre_op2;
						post_d  = 1'b1;
					end else begin
						state_d = plan.rec_en ? CS_WRITE : CS_DONE;
					end
				end
			end
			CS_LOOK_A: begin
				if (in_range(look_r)) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = to_idx(look_r);
					state_d         = CS_LOOK_B;
				end else begin
					res_load = 1'b1;
					state_d  = look_next;
					op2_d    = look_op2;
				end
			end
			CS_LOOK_B: begin
				if (rd_data.valid && in_range(rd_data.src)) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = to_idx(rd_data.src);
					mid_load        = 1'b1;
					state_d         = CS_LOOK_C;
				end else begin
					res_load = 1'b1;
					res_val  = rd_data.valid ? rd_data.src : look_r;
					state_d  = look_next;
					op2_d    = look_op2;
				end
			end
			CS_LOOK_C: begin
				res_load = 1'b1;
				res_val  = rd_data.valid ? rd_data.src : mid_q;
				state_d  = look_next;
				op2_d    = look_op2;
			end
			CS_WRITE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = to_idx(plan.rec_dest);
				mem_req.wr_data = '{valid: 1'b1, src: plan.rec_src};
				state_d         = CS_DONE;
			end
			CS_DONE: begin
				done = 1'b1;
				if (take) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// Sequencer state; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_SWEEP;
			init_q     <= 1'b1;
			post_q     <= 1'b1;
			op2_q      <= 1'b0;
			cnt_q      <= '0;
			sweep_v_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			init_q     <= init_d;
			post_q     <= post_d;
			op2_q      <= op2_d;
			sweep_v_s1 <= (state_q == CS_SWEEP) && mem_req.rd_en;
			// Rewind at the end of each pass so a second pass starts from entry zero
			if (state_q == CS_SWEEP && 32'(cnt_q) != 32'(NUM_REGS)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Hold sweep address and lookup results
	always_ff @(posedge clk) begin
		sweep_addr_s1 <= mem_req.rd_addr;
		if (mid_load) begin
			mid_q <= rd_data.src;
		end
		if (res_load) begin
			if (op2_q) begin
				t2_q <= res_val;
			end else begin
				t1_q <= res_val;
			end
		end
	end

	assign t1 = t1_q;
	assign t2 = t2_q;

endmodule

// ===== sv/register_copy_forwarding_table.sv =====
// Copy-forwarding table: takes one instruction word at a time, rewrites its register
// sources through at most two levels of recorded copies and returns one result word
// per item. Invalidation is done by a pass over the whole table memory, one entry per
// cycle; an item needs none, one or two such passes (a clear or pending invalidation
// before lookup, a destination invalidation after it). Lookups share the single read
// port of the table: the first level reads the entry of the source register, the
// second the entry that it points to. After reset the block runs one clearing pass
// and holds item_stall high until it ends. The result sits in an output register, so
// the next item is taken while the previous result waits.
`timescale 1ns / 1ps

module register_copy_forwarding_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           action,
	input  logic                 clobbers_memory,
	input  logic                 is_move,
	input  logic                 defines_dest,
	input  rcft_pkg::reg_t       dest_reg,
	input  logic                 src1_is_reg,
	input  rcft_pkg::reg_t       src1_reg,
	input  logic                 src2_is_reg,
	input  rcft_pkg::reg_t       src2_reg,
	input  logic                 has_extra_args,
	input  logic                 last_arg,
	output logic                 result_valid,
	input  logic                 result_stall,
	output rcft_pkg::reg_t       out_src1,
	output rcft_pkg::reg_t       out_src2,
	output logic [1:0]           replaced_count
);
	import rcft_pkg::*;

	action_t  act;
	logic     blk, instr, arg;
	logic     accept, take;
	logic     busy_q, start_q;
	logic     pend_v_q;
	reg_t     pend_d_q;
	plan_t    plan_d, plan_q;
	logic     result_valid_q;
	reg_t     out_src1_q, out_src2_q;
	logic [1:0] count_q;
	mem_req_t mem_req;
	entry_t   rd_data;
	logic     ctrl_idle, ctrl_done;
	reg_t     t1, t2;
	logic [1:0] count_d;

	assign act   = action_t'(action);
	assign blk   = act == ACT_BLOCK;
	assign instr = act == ACT_INSTR;
	assign arg   = act == ACT_ARG;

	assign item_stall = busy_q || !ctrl_idle;
	assign accept     = item_valid && !item_stall;
	assign take       = ctrl_done && (!result_valid_q || !result_stall);

	// Decode the incoming word into its work list
	always_comb begin
		plan_d.pre_clear = blk || (instr && clobbers_memory);
		plan_d.ka_en     = instr && pend_v_q && in_range(pend_d_q);
		plan_d.ka        = pend_d_q;
		plan_d.kb_en     = instr && is_move && defines_dest && in_range(dest_reg);
		plan_d.kb        = dest_reg;
		plan_d.look1     = ((instr && !is_move) || arg) && src1_is_reg;
		plan_d.r1        = src1_reg;
		plan_d.look2     = instr && !is_move && src2_is_reg;
		plan_d.r2        = src2_reg;
		plan_d.pass1     = instr || arg;
		plan_d.pass2     = instr;
		plan_d.post_en   = (instr && !is_move && defines_dest && !has_extra_args &&
			in_range(dest_reg)) || (arg && last_arg && pend_v_q && in_range(pend_d_q));
		plan_d.post_r    = instr ? dest_reg : pend_d_q;
		plan_d.rec_en    = instr && is_move && defines_dest && src1_is_reg &&
			in_range(dest_reg);
		plan_d.rec_dest  = dest_reg;
		plan_d.rec_src   = src1_reg;
	end

	// Latch the work list
	always_ff @(posedge clk) begin
		if (accept) begin
			plan_q <= plan_d;
		end
	end

	// Track the busy item and the deferred destination
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			start_q  <= 1'b0;
			pend_v_q <= 1'b0;
			pend_d_q <= '0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (act)
					ACT_BLOCK: begin
						pend_v_q <= 1'b0;
						pend_d_q <= '0;
					end
					ACT_INSTR: begin
						if (!is_move && defines_dest && has_extra_args) begin
							pend_v_q <= 1'b1;
							pend_d_q <= dest_reg;
						end else begin
							pend_v_q <= 1'b0;
						end
					end
					ACT_ARG: begin
						if (last_arg) begin
							pend_v_q <= 1'b0;
						end
					end
					default: begin
						pend_v_q <= pend_v_q;
					end
				endcase
			end
		end
	end

	// Count operands that changed
	assign count_d = {1'b0, plan_q.look1 && (t1 != plan_q.r1)} +
		{1'b0, plan_q.look2 && (t2 != plan_q.r2)};

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_src1_q <= plan_q.look1 ? t1 : (plan_q.pass1 ? plan_q.r1 : '0);
			out_src2_q <= plan_q.look2 ? t2 : (plan_q.pass2 ? plan_q.r2 : '0);
			count_q    <= count_d;
		end
	end

	assign result_valid   = result_valid_q;
	assign out_src1       = out_src1_q;
	assign out_src2       = out_src2_q;
	assign replaced_count = count_q;

	rcft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.plan    (plan_q),
		.take    (take),
		.rd_data (rd_data),
		.mem_req (mem_req),
		.idle    (ctrl_idle),
		.done    (ctrl_done),
		.t1      (t1),
		.t2      (t2)
	);

	rcft_table u_table (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data)
	);

endmodule

// ===== sv/rcft_checker.sv =====
`timescale 1ns / 1ps

module rcft_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_stall,
	input logic           result_valid,
	input logic           result_stall,
	input rcft_pkg::reg_t out_src1,
	input rcft_pkg::reg_t out_src2,
	input logic [1:0]     replaced_count
);
	import rcft_pkg::*;

	// One word at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input accepted twice in a row");

	// At most two operands can be replaced
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (replaced_count != 2'd3))
		else $error("replaced count out of range");

	// A fresh result only comes from a word in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without work in progress");

	// Hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(out_src1) &&
		$stable(out_src2) && $stable(replaced_count)))
		else $error("stalled result changed");

endmodule

bind register_copy_forwarding_table rcft_checker u_rcft_checker (.*);

// ===== bench/register_copy_forwarding_table_test.sv =====
`timescale 1ns / 1ps

module register_copy_forwarding_table_test;
	import rcft_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam bit N = 1'b0;
	localparam bit Y = 1'b1;
	localparam int RANDOM_WORDS = 560;
	localparam int CALM_WORDS = 60;
	localparam int HOLD_CYCLES = 4000;
	// a word may need two sweeps of the whole table
	localparam int TAIL_CYCLES = 2 * (NUM_REGS + 1) + 20;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] action;
		logic       clob;
		logic       mov;
		logic       defd;
		reg_t       dest;
		logic       s1r;
		reg_t       s1;
		logic       s2r;
		reg_t       s2;
		logic       extra;
		logic       last;
	} in_word_t;

	typedef struct packed {
		reg_t       src1;
		reg_t       src2;
		logic [1:0] count;
	} out_word_t;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} stim_row_t;

	localparam out_word_t NO_RES = '0;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_word_t  cur = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	reg_t      out_src1;
	reg_t      out_src2;
	logic [1:0] replaced_count;

	// Copy table mirror
	reg_t copy_of [NUM_REGS];
	bit   copy_live [NUM_REGS];
	reg_t defer_dest = '0;
	bit   defer_live = 1'b0;

	out_word_t awaited_results [$];
	int words_in = 0;
	int results_seen = 0;
	int forwarded = 0;
	int mismatches = 0;
	int idle_pct = 20;
	int quiet = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	bit holding = 1'b0;

	// Directed words; typed results where they are plain to see
	stim_row_t stim_rows [] = '{
		'{'{ACT_BLOCK, Y, Y, Y, 10'd1023, Y, 10'd1023, Y, 10'd1023, Y, Y}, Y, NO_RES},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd1023, Y, 10'd0, Y, Y}, Y,
			'{10'd1023, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, Y, Y, 10'd5, Y, 10'd1023, Y, 10'd7, Y, N}, Y,
			'{10'd1023, 10'd7, 2'd0}},
		'{'{ACT_INSTR, N, Y, Y, 10'd6, Y, 10'd5, N, 10'd0, N, N}, Y, '{10'd5, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, N, N, 10'd0, N, 10'd6, Y, 10'd6, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, N, Y, 10'd1023, Y, 10'd5, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd6, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_ARG, Y, Y, Y, 10'd1023, Y, 10'd6, Y, 10'd1023, Y, Y}, N, NO_RES},
		'{'{ACT_INSTR, N, N, Y, 10'd5, Y, 10'd6, N, 10'd0, Y, N}, N, NO_RES},
		'{'{ACT_ARG, N, N, N, 10'd0, Y, 10'd6, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_ARG, N, N, N, 10'd0, Y, 10'd6, N, 10'd0, N, Y}, N, NO_RES},
		'{'{ACT_INSTR, N, Y, Y, 10'd10, Y, 10'd6, N, 10'd0, N, N}, Y, '{10'd6, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, N, Y, 10'd6, N, 10'd0, N, 10'd0, Y, N}, N, NO_RES},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd10, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, Y, Y, 10'd20, Y, 10'd21, N, 10'd0, N, N}, Y, '{10'd21, 10'd0, 2'd0}},
		'{'{ACT_INSTR, Y, N, N, 10'd0, Y, 10'd20, Y, 10'd20, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, Y, Y, 10'd20, Y, 10'd21, N, 10'd0, N, N}, Y, '{10'd21, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, Y, Y, 10'd20, N, 10'd21, N, 10'd0, N, N}, Y, '{10'd21, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd20, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, N, Y, 10'd30, N, 10'd0, N, 10'd0, Y, N}, N, NO_RES},
		'{'{ACT_BLOCK, N, N, N, 10'd0, N, 10'd0, N, 10'd0, N, N}, Y, NO_RES},
		'{'{ACT_UNUSED, Y, Y, Y, 10'd1023, Y, 10'd1023, Y, 10'd1023, Y, Y}, Y, NO_RES},
		'{'{ACT_INSTR, N, Y, Y, 10'd40, Y, 10'd40, N, 10'd0, N, N}, Y, '{10'd40, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd40, N, 10'd0, N, N}, N, NO_RES},
		'{'{ACT_INSTR, N, Y, Y, 10'd52, Y, 10'd53, N, 10'd0, N, N}, Y, '{10'd53, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, Y, Y, 10'd51, Y, 10'd52, N, 10'd0, N, N}, Y, '{10'd52, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, Y, Y, 10'd50, Y, 10'd51, N, 10'd0, N, N}, Y, '{10'd51, 10'd0, 2'd0}},
		'{'{ACT_INSTR, N, N, N, 10'd0, Y, 10'd50, Y, 10'd51, N, N}, N, NO_RES}
	};

	register_copy_forwarding_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.action         (cur.action),
		.clobbers_memory(cur.clob),
		.is_move        (cur.mov),
		.defines_dest   (cur.defd),
		.dest_reg       (cur.dest),
		.src1_is_reg    (cur.s1r),
		.src1_reg       (cur.s1),
		.src2_is_reg    (cur.s2r),
		.src2_reg       (cur.s2),
		.has_extra_args (cur.extra),
		.last_arg       (cur.last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_src1       (out_src1),
		.out_src2       (out_src2),
		.replaced_count (replaced_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void wipe_table();
		foreach (copy_live[i]) copy_live[i] = 1'b0;
	endfunction

	// Drop an entry and every entry that copies from it
	function automatic void drop_reg(reg_t r);
		if (32'(r) >= NUM_REGS) return;
		copy_live[r] = 1'b0;
		foreach (copy_live[i]) begin
			if (copy_live[i] && copy_of[i] == r) copy_live[i] = 1'b0;
		end
	endfunction

	// Follow at most two levels of copies
	function automatic reg_t resolve(reg_t r);
		reg_t s;
		if (32'(r) >= NUM_REGS || !copy_live[r]) return r;
		s = copy_of[r];
		if (32'(s) < NUM_REGS && copy_live[s]) s = copy_of[s];
		return s;
	endfunction

	// Advance the table mirror by one word and return the rewritten operands
	function automatic out_word_t forward_word(in_word_t w);
		out_word_t r;
		r = '0;
		case (w.action)
			ACT_BLOCK: begin
				wipe_table();
				defer_live = 1'b0;
				defer_dest = '0;
			end
			ACT_INSTR: begin
				if (defer_live) begin
					drop_reg(defer_dest);
					defer_live = 1'b0;
				end
				if (w.clob) wipe_table();
				r.src1 = w.s1;
				r.src2 = w.s2;
				if (w.mov) begin
					if (w.defd) begin
						drop_reg(w.dest);
						if (w.s1r && 32'(w.dest) < NUM_REGS) begin
							copy_of[w.dest] = w.s1;
							copy_live[w.dest] = 1'b1;
						end
					end
				end else begin
					if (w.s1r) begin
						r.src1 = resolve(w.s1);
						if (r.src1 != w.s1) r.count = r.count + 2'd1;
					end
					if (w.s2r) begin
						r.src2 = resolve(w.s2);
						if (r.src2 != w.s2) r.count = r.count + 2'd1;
					end
					if (w.defd) begin
						if (w.extra) begin
							defer_dest = w.dest;
							defer_live = 1'b1;
						end else begin
							drop_reg(w.dest);
						end
					end
				end
			end
			ACT_ARG: begin
				r.src1 = w.s1;
				if (w.s1r) begin
					r.src1 = resolve(w.s1);
					if (r.src1 != w.s1) r.count = r.count + 2'd1;
				end
				if (w.last && defer_live) begin
					drop_reg(defer_dest);
					defer_live = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Mostly a small pool at both ends of the register space, sometimes anywhere
	function automatic reg_t pick_reg();
		if ($urandom_range(0, 4) == 0) return reg_t'($urandom_range(0, NUM_REGS - 1));
		if ($urandom_range(0, 1) == 0) return reg_t'($urandom_range(0, 7));
		return reg_t'(NUM_REGS - 8 + $urandom_range(0, 7));
	endfunction

	function automatic in_word_t noise_word();
		logic [63:0] bits;
		in_word_t w;
		bits = {$urandom, $urandom};
		w = bits[$bits(in_word_t)-1:0];
		w.dest = pick_reg();
		w.s1 = pick_reg();
		w.s2 = pick_reg();
		return w;
	endfunction

	// Offer one word, hold it until taken, then record what should come back
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
		out_word_t predicted;
		if (!calm && !holding && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		cur <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predicted = forward_word(w);
		awaited_results.push_back(typed ? typed_res : predicted);
		if (w.action != ACT_UNUSED) words_in++;
	endtask

	// One random sequence: mostly well-formed instructions, some noise
	task automatic send_random_burst();
		in_word_t w;
		in_word_t arg;
		int kind;
		int nargs;
		bit broken;
		w = noise_word();
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			// register move
			w.action = ACT_INSTR;
			w.clob = 1'b0;
			w.mov = 1'b1;
			w.defd = ($urandom_range(0, 9) != 0);
			w.s1r = ($urandom_range(0, 7) != 0);
			send_word(w, N, NO_RES);
		end else if (kind < 64) begin
			// plain operation
			w.action = ACT_INSTR;
			w.clob = 1'b0;
			w.mov = 1'b0;
			w.extra = 1'b0;
			w.s1r = ($urandom_range(0, 5) != 0);
			w.s2r = ($urandom_range(0, 3) != 0);
			send_word(w, N, NO_RES);
		end else if (kind < 78) begin
			// call followed by its argument words, now and then left open
			w.action = ACT_INSTR;
			w.mov = 1'b0;
			w.defd = 1'b1;
			w.extra = 1'b1;
			send_word(w, N, NO_RES);
			nargs = $urandom_range(1, 3);
			broken = ($urandom_range(0, 6) == 0);
			for (int i = 1; i <= nargs; i++) begin
				arg = noise_word();
				arg.action = ACT_ARG;
				arg.s1r = ($urandom_range(0, 5) != 0);
				arg.last = (i == nargs) && !broken;
				send_word(arg, N, NO_RES);
			end
		end else if (kind < 84) begin
			// store
			w.action = ACT_INSTR;
			w.clob = 1'b1;
			w.mov = 1'b0;
			send_word(w, N, NO_RES);
		end else if (kind < 88) begin
			w.action = ACT_BLOCK;
			send_word(w, N, NO_RES);
		end else if (kind < 94) begin
			// argument word with no call ahead of it
			w.action = ACT_ARG;
			send_word(w, N, NO_RES);
		end else begin
			send_word(w, N, NO_RES);
		end
	endtask

	task automatic report_mismatch(input string what, input out_word_t want,
			input out_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected src1=%0d src2=%0d count=%0d, got src1=%0d src2=%0d count=%0d",
				$time, what, want.src1, want.src2, want.count,
				got.src1, got.src2, got.count);
	endtask

	// Check each result word against the oldest awaited one
	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (result_valid && !result_stall) begin
			got.src1 = out_src1;
			got.src2 = out_src2;
			got.count = replaced_count;
			results_seen++;
			if (got.count != 2'd0) forwarded++;
			if (awaited_results.size() == 0) begin
				report_mismatch("result with none awaited", NO_RES, got);
			end else begin
				want = awaited_results.pop_front();
				if (got.src1 !== want.src1 || got.src2 !== want.src2 ||
						got.count !== want.count)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Receiver: random stall bursts, and one long hold-off to fill the block
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				holding = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				holding = 1'b0;
			end else if (!calm && $urandom_range(0, 199) < idle_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("register_copy_forwarding_table verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int phase_mark;
		int directed_words;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) send_word(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].res);
		directed_words = words_in;
		phase_mark = words_in;

		while (words_in - directed_words < RANDOM_WORDS) begin
			// change the idling level every hundred words or so
			if (words_in - phase_mark >= 100) begin
				phase_mark = words_in;
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			end
			if (!hold_go && words_in - directed_words >= 200) hold_go = 1'b1;
			if (words_in - directed_words >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
			send_random_burst();
		end
		item_valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words sent, %0d results checked, %0d with operands forwarded",
			words_in, results_seen, forwarded);
		$display("moves, operations, calls with argument words, stores, block starts, "
			, "stray and unused words, idling bursts and one long output hold-off");
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("register_copy_forwarding_table verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				awaited_results.size());
			$display("register_copy_forwarding_table verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/rcft_pkg.sv
sv/rcft_table.sv
sv/rcft_ctrl.sv
sv/register_copy_forwarding_table.sv
sv/rcft_checker.sv
bench/register_copy_forwarding_table_test.sv
